// ===== rtl/multi_voice_adsr_envelope_core_macros.svh =====
// ----------------------------------------------------------------------------
// Envelope core assertion macros
// Shared assertion forms for the envelope core, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_ADSR_ENVELOPE_CORE_MACROS_SVH
`define MULTI_VOICE_ADSR_ENVELOPE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MVAE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("envelope core check failed");
`define MVAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("envelope core check failed");
`else
`define MVAE_ASSERT_SAME(label, ante, cons)
`define MVAE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/mvae_pkg.sv =====
// ----------------------------------------------------------------------------
// Envelope core package
// Types, codes and shared arithmetic for the multi-voice envelope core.
// ----------------------------------------------------------------------------
package mvae_pkg;

    localparam int NUM_VOICES = 16;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    localparam int LEVEL_W = 23;
    localparam int FADE_W  = 24;
    localparam int FRAC_W  = 16;
    localparam int WHOLE_W = LEVEL_W - FRAC_W;
    localparam int VEL_W   = 7;
    localparam int PROD_W  = VEL_W + WHOLE_W;
    localparam int CHAN_W  = 8;
    localparam int VOL_W   = 8;
    localparam int ENV_W   = 26;

    localparam logic signed [ENV_W-1:0] LEVEL_CEIL = ENV_W'(127 * 65536);
    localparam logic signed [ENV_W-1:0] FORCE_RATE = ENV_W'(6 * 65536);

    localparam logic [1:0] REQ_TICK       = 2'd0;
    localparam logic [1:0] REQ_NOTE_ON    = 2'd1;
    localparam logic [1:0] REQ_NOTE_OFF   = 2'd2;
    localparam logic [1:0] REQ_FORCE_STOP = 2'd3;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ATTACK  = 3'd1;
    localparam logic [2:0] ST_DECAY   = 3'd2;
    localparam logic [2:0] ST_SUSTAIN = 3'd3;
    localparam logic [2:0] ST_RELEASE = 3'd4;
    localparam logic [2:0] ST_FORCE   = 3'd5;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [3:0]                voice;
        logic [LEVEL_W-1:0]        initial_level;
        logic [LEVEL_W-1:0]        attack_rate;
        logic [LEVEL_W-1:0]        decay_rate;
        logic [LEVEL_W-1:0]        sustain_level;
        logic signed [FADE_W-1:0]  fade_rate;
        logic [LEVEL_W-1:0]        release_rate;
        logic [VEL_W-1:0]          note_velocity;
        logic [CHAN_W-1:0]         channel_volume;
        logic                      uses_channel_volume;
    } req_t;

    typedef struct packed {
        logic [3:0]         voice_out;
        logic [2:0]         stage_out;
        logic [LEVEL_W-1:0] level_out;
        logic [VOL_W-1:0]   volume_out;
        logic               finished;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

    function automatic logic [VOL_W-1:0] calc_volume(
        input logic [PROD_W-1:0] prod,
        input logic [CHAN_W-1:0] chan,
        input logic              use_chan
    );
        logic [CHAN_W+PROD_W-1:0] full;
        full = (CHAN_W+PROD_W)'(chan) * (CHAN_W+PROD_W)'(prod);
        if (use_chan)
        begin
            return full[CHAN_W+PROD_W-1:CHAN_W+PROD_W-VOL_W];
        end
        return VOL_W'(prod[PROD_W-1:VEL_W]);
    endfunction

endpackage

// ===== rtl/multi_voice_adsr_envelope_core.sv =====
// The response register is loaded as S_CALC ends, once the response slot is
// free. No new request is taken until then, set by the single read-modify-write
// of the voice memory (read on accept, write on update). A stalled response
// holds the next request back only while the update waits.
// Reset clears the per-voice valid bits at once, so every voice reads as idle
// with level zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Multi-voice envelope core
// Per-voice attack, decay, sustain and release envelope engine with a
// volume product, built as a controller and a datapath.
// ----------------------------------------------------------------------------
`include "multi_voice_adsr_envelope_core_macros.svh"

module multi_voice_adsr_envelope_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  mvae_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output mvae_pkg::rsp_t   rsp
);

    mvae_pkg::cmd_t cmd;

    mvae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    mvae_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    `MVAE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    `MVAE_ASSERT_SAME(a_finish_idles, rsp_valid && rsp.finished, rsp.stage_out == mvae_pkg::ST_IDLE)
    `MVAE_ASSERT_SAME(a_rsp_after_calc, $rose(rsp_valid), $past(!req_ready))
    `MVAE_ASSERT_SAME(a_exec_needs_slot, cmd.execute, !rsp_valid || rsp_ready)

endmodule

// ===== rtl/mvae_ctrl.sv =====
// ----------------------------------------------------------------------------
// Envelope core controller
// Two-state sequencer that captures a request, runs one read-modify-write
// of the voice memory and loads the response register.
// ----------------------------------------------------------------------------
module mvae_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mvae_pkg::cmd_t     cmd
);

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

    state_t state_reg;
    logic   req_ready_reg;
    logic   rsp_valid_reg;
    logic   slot_free;

    assign slot_free   = !rsp_valid_reg || rsp_ready;
    assign cmd.capture = req_valid && req_ready_reg;
    assign cmd.execute = (state_reg == S_CALC) && slot_free;
    assign req_ready   = req_ready_reg;
    assign rsp_valid   = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_ready_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                    if (req_valid)
                    begin
                        state_reg     <= S_CALC;
                        req_ready_reg <= 1'b0;
                    end
                end
                S_CALC:
                begin
                    if (slot_free)
                    begin
                        state_reg     <= S_IDLE;
                        req_ready_reg <= 1'b1;
                        rsp_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/mvae_dp.sv =====
// ----------------------------------------------------------------------------
// Envelope core datapath
// Voice memory, envelope stage update, volume product and response register.
// ----------------------------------------------------------------------------
module mvae_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  mvae_pkg::req_t   req,
    input  mvae_pkg::cmd_t   cmd,
    output mvae_pkg::rsp_t   rsp
);

    typedef struct packed {
        logic [2:0]                         stage;
        logic [mvae_pkg::LEVEL_W-1:0]       level;
        logic [mvae_pkg::LEVEL_W-1:0]       attack;
        logic [mvae_pkg::LEVEL_W-1:0]       decay;
        logic [mvae_pkg::LEVEL_W-1:0]       sustain;
        logic signed [mvae_pkg::FADE_W-1:0] fade;
        logic [mvae_pkg::LEVEL_W-1:0]       release_rate;
        logic [mvae_pkg::VEL_W-1:0]         velocity;
        logic [mvae_pkg::PROD_W-1:0]        prod;
    } voice_rec_t;

    voice_rec_t                    mem [mvae_pkg::NUM_VOICES];
    logic [mvae_pkg::NUM_VOICES-1:0] vld_reg;

    mvae_pkg::req_t                req_reg;
    voice_rec_t                    rd_reg;
    logic                          rd_vld_reg;
    logic                          in_range_reg;
    logic [mvae_pkg::PROD_W-1:0]   np_reg;
    mvae_pkg::rsp_t                rsp_reg;
    mvae_pkg::rsp_t                rsp_next;

    logic [mvae_pkg::VIDX_W-1:0]   cap_idx;
    logic [mvae_pkg::VIDX_W-1:0]   wr_idx;
    logic                          cap_in_range;
    voice_rec_t                    cur;
    voice_rec_t                    rec_next;
    logic signed [mvae_pkg::ENV_W-1:0] lvl_ext;
    logic signed [mvae_pkg::ENV_W-1:0] env;
    logic signed [mvae_pkg::ENV_W-1:0] rate;
    logic [mvae_pkg::VOL_W-1:0]    vol;
    logic                          fin;

    assign cap_idx      = mvae_pkg::VIDX_W'(req.voice);
    assign wr_idx       = mvae_pkg::VIDX_W'(req_reg.voice);
    assign cap_in_range = (32'(req.voice) < 32'(mvae_pkg::NUM_VOICES));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= req;
            in_range_reg <= cap_in_range;
            np_reg       <= mvae_pkg::PROD_W'(req.note_velocity)
                          * mvae_pkg::PROD_W'(req.initial_level[mvae_pkg::LEVEL_W-1:
                                                                 mvae_pkg::FRAC_W]);
            if (cap_in_range)
            begin
                rd_reg     <= mem[cap_idx];
                rd_vld_reg <= vld_reg[cap_idx];
            end
            else
            begin
                rd_vld_reg <= 1'b0;
            end
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
            if (in_range_reg)
            begin
                mem[wr_idx] <= rec_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.execute && in_range_reg)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_comb
    begin
        cur = rd_reg;
        if (!rd_vld_reg)
        begin
            cur.stage = mvae_pkg::ST_IDLE;
            cur.level = '0;
            cur.prod  = '0;
        end
        rec_next = cur;
        vol      = '0;
        fin      = 1'b0;
        lvl_ext  = $signed({{(mvae_pkg::ENV_W-mvae_pkg::LEVEL_W){1'b0}}, cur.level});
        env      = lvl_ext;
        rate     = '0;
        case (req_reg.req_type) inside
            mvae_pkg::REQ_NOTE_ON:
            begin
                rec_next.stage        = mvae_pkg::ST_ATTACK;
                rec_next.level        = req_reg.initial_level;
                rec_next.attack       = req_reg.attack_rate;
                rec_next.decay        = req_reg.decay_rate;
                rec_next.sustain      = req_reg.sustain_level;
                rec_next.fade         = req_reg.fade_rate;
                rec_next.release_rate = req_reg.release_rate;
                rec_next.velocity     = req_reg.note_velocity;
                rec_next.prod         = np_reg;
                vol = mvae_pkg::calc_volume(np_reg, req_reg.channel_volume,
                                            req_reg.uses_channel_volume);
            end
            mvae_pkg::REQ_NOTE_OFF, mvae_pkg::REQ_FORCE_STOP:
            begin
                if (cur.stage != mvae_pkg::ST_IDLE)
                begin
                    rec_next.stage = (req_reg.req_type == mvae_pkg::REQ_NOTE_OFF)
                                   ? mvae_pkg::ST_RELEASE : mvae_pkg::ST_FORCE;
                end
            end
            default:
            begin
                if (cur.stage != mvae_pkg::ST_IDLE)
                begin
                    vol = mvae_pkg::calc_volume(cur.prod, req_reg.channel_volume,
                                                req_reg.uses_channel_volume);
                    case (cur.stage) inside
                        mvae_pkg::ST_ATTACK:
                        begin
                            env = lvl_ext + $signed(mvae_pkg::ENV_W'(cur.attack));
                            if (env >= mvae_pkg::LEVEL_CEIL)
                            begin
                                env            = mvae_pkg::LEVEL_CEIL;
                                rec_next.stage = mvae_pkg::ST_DECAY;
                            end
                        end
                        mvae_pkg::ST_DECAY:
                        begin
                            env = lvl_ext - $signed(mvae_pkg::ENV_W'(cur.decay));
                            if (env <= $signed(mvae_pkg::ENV_W'(cur.sustain)))
                            begin
                                env            = $signed(mvae_pkg::ENV_W'(cur.sustain));
                                rec_next.stage = mvae_pkg::ST_SUSTAIN;
                            end
                        end
                        mvae_pkg::ST_SUSTAIN:
                        begin
                            env = lvl_ext - $signed({{(mvae_pkg::ENV_W-mvae_pkg::FADE_W)
                                                      {cur.fade[mvae_pkg::FADE_W-1]}},
                                                     cur.fade});
                            if (env >= mvae_pkg::LEVEL_CEIL)
                            begin
                                env = mvae_pkg::LEVEL_CEIL;
                            end
                            else if (env <= 0)
                            begin
                                env = '0;
                                fin = 1'b1;
                            end
                        end
                        mvae_pkg::ST_RELEASE, mvae_pkg::ST_FORCE:
                        begin
                            rate = $signed(mvae_pkg::ENV_W'(cur.release_rate));
                            if ((cur.stage == mvae_pkg::ST_FORCE) && (cur.release_rate == '0))
                            begin
                                rate = mvae_pkg::FORCE_RATE;
                            end
                            env = lvl_ext - rate;
                            if (env <= 0)
                            begin
                                env = '0;
                                fin = 1'b1;
                            end
                        end
                        default:
                        begin
                            rec_next.stage = mvae_pkg::ST_IDLE;
                        end
                    endcase
                    rec_next.level = env[mvae_pkg::LEVEL_W-1:0];
                    rec_next.prod  = mvae_pkg::PROD_W'(cur.velocity)
                                   * mvae_pkg::PROD_W'(env[mvae_pkg::LEVEL_W-1:
                                                           mvae_pkg::FRAC_W]);
                    if (fin)
                    begin
                        rec_next.stage = mvae_pkg::ST_IDLE;
                    end
                end
            end
        endcase

        rsp_next.voice_out = req_reg.voice;
        if (in_range_reg)
        begin
            rsp_next.stage_out  = rec_next.stage;
            rsp_next.level_out  = rec_next.level;
            rsp_next.volume_out = vol;
            rsp_next.finished   = fin;
        end
        else
        begin
            rsp_next.stage_out  = mvae_pkg::ST_IDLE;
            rsp_next.level_out  = '0;
            rsp_next.volume_out = '0;
            rsp_next.finished   = 1'b0;
        end
    end

    assign rsp = rsp_reg;

endmodule
